### hdl/bcm_pkg.sv
// ----------------------------------------------------------------------------
// bcm_pkg
// Shared types for the classification metrics block: the back-end sequencer
// states, the metric codes and the queue status that flows between the parts.
// ----------------------------------------------------------------------------
package bcm_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_HOLD
   } back_state_type;

   typedef enum logic [1:0] {
      OP_ACCURACY,
      OP_PRECISION,
      OP_RECALL,
      OP_F1
   } metric_op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

### hdl/binary_classification_metrics.sv
// ----------------------------------------------------------------------------
// binary_classification_metrics
// Streaming binary classifier scoring: counts, accuracy, precision, recall
// and F1 per set of label pairs.
// ----------------------------------------------------------------------------
// The block takes one label pair per clock on the req stream, with req_tlast
// marking the end of a set, and gives one rsp beat per set carrying the
// saturating counts and four unsigned ratios with FRACTION_BITS fraction bits.
// The front end counts one beat per cycle while the queue is not full. At a
// set end it hands a snapshot to a two-entry queue and starts the next set
// at once. The back end derives the ratios with one shared restoring
// divider producing one quotient bit per cycle, and gives the rsp beat of a
// set once all four ratios are done. req_tready drops only while both queue
// entries hold sets that await the divider, which happens when short sets
// arrive in a row faster than the divider clears them or rsp stalls.
// ----------------------------------------------------------------------------
module binary_classification_metrics #(
   parameter int COUNT_BITS    = 20,
   parameter int FRACTION_BITS = 16,
   parameter int LABEL_BITS    = 8,
   localparam int REQ_BITS     = ((2 * LABEL_BITS + 7) / 8) * 8,
   localparam int RSP_FIELDS   = 5 * COUNT_BITS + 4 * (FRACTION_BITS + 1),
   localparam int RSP_BITS     = ((RSP_FIELDS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // {predicted_label, true_label} from bit 0 up: true_label, predicted_label
   input  logic [REQ_BITS-1:0] req_tdata,
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // from bit 0 up: true_positives, false_positives, false_negatives,
   // matches_res, sample_count, accuracy, precision, recall, f1_score
   output logic [RSP_BITS-1:0] rsp_tdata,
   // bit 0: status
   output logic                rsp_tuser
);
   import bcm_pkg::*;

   localparam int SNAP_BITS = 5 * COUNT_BITS + 1;

   q_status_type           q_status;
   logic                   snap_push, snap_pop;
   logic [SNAP_BITS-1:0]   push_data, pop_data;
   logic [RSP_FIELDS-1:0]  rsp_fields;

   bcm_front #(
      .COUNT_BITS (COUNT_BITS),
      .LABEL_BITS (LABEL_BITS),
      .SNAP_BITS  (SNAP_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (req_tvalid),
      .item_ready      (req_tready),
      .true_label      (req_tdata[LABEL_BITS-1:0]),
      .predicted_label (req_tdata[2*LABEL_BITS-1:LABEL_BITS]),
      .last_item       (req_tlast),
      .q_status        (q_status),
      .snap_push       (snap_push),
      .snap_data       (push_data)
   );

   bcm_queue #(
      .SNAP_BITS (SNAP_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (snap_push),
      .push_data (push_data),
      .pop       (snap_pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   bcm_back #(
      .COUNT_BITS    (COUNT_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .SNAP_BITS     (SNAP_BITS),
      .RSP_BITS      (RSP_FIELDS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .snap_data  (pop_data),
      .snap_pop   (snap_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp_fields),
      .rsp_status (rsp_tuser)
   );

   assign rsp_tdata = RSP_BITS'(rsp_fields);

endmodule

### hdl/bcm_front.sv
// ----------------------------------------------------------------------------
// bcm_front
// Accepts label pairs, updates the saturating counters and the distinct-label
// tracking, and pushes a snapshot of the finished set into the queue.
// ----------------------------------------------------------------------------
module bcm_front #(
   parameter int COUNT_BITS = 20,
   parameter int LABEL_BITS = 8,
   parameter int SNAP_BITS  = 101
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   output logic                    item_ready,
   input  logic [LABEL_BITS-1:0]   true_label,
   input  logic [LABEL_BITS-1:0]   predicted_label,
   input  logic                    last_item,
   input  bcm_pkg::q_status_type   q_status,
   output logic                    snap_push,
   output logic [SNAP_BITS-1:0]    snap_data
);
   import bcm_pkg::*;

   localparam int CLS_BITS = 2 * LABEL_BITS + 3;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [LABEL_BITS-1:0] LABEL_ONE = LABEL_BITS'(1);
   localparam logic [LABEL_BITS-1:0] LABEL_ZERO = '0;

   logic [COUNT_BITS-1:0] tp_ff, fp_ff, fn_ff, match_ff, items_ff;
   logic [COUNT_BITS-1:0] tp_in, fp_in, fn_in, match_in, items_in;
   logic [CLS_BITS-1:0]   cls_ff, cls_mid, cls_in;
   logic                  accept;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
      return (c == COUNT_MAX) ? c : c + COUNT_BITS'(1);
   endfunction

   // cls packs {overflow, seen[1:0], second, first}
   function automatic logic [CLS_BITS-1:0] note_label(input logic [LABEL_BITS-1:0] v,
                                                      input logic [CLS_BITS-1:0] cls);
      logic [LABEL_BITS-1:0] first;
      logic [LABEL_BITS-1:0] second;
      logic [1:0]            seen;
      logic                  ovf;
      {ovf, seen, second, first} = cls;
      if (!((seen >= 2'd1 && v == first) || (seen >= 2'd2 && v == second))) begin
         priority if (seen == 2'd0) begin
            first = v;
            seen  = 2'd1;
         end else if (seen == 2'd1) begin
            second = v;
            seen   = 2'd2;
         end else begin
            ovf = 1'b1;
         end
      end
      return {ovf, seen, second, first};
   endfunction

   // a set end needs a free queue slot; hold off while the queue is full
   assign item_ready = !q_status.full;
   assign accept     = item_valid && item_ready;

   always_comb begin
      tp_in    = tp_ff;
      fp_in    = fp_ff;
      fn_in    = fn_ff;
      match_in = match_ff;
      items_in = sat_inc(items_ff);
      priority if (true_label == LABEL_ONE && predicted_label == LABEL_ONE) begin
         tp_in = sat_inc(tp_ff);
      end else if (true_label == LABEL_ZERO && predicted_label == LABEL_ONE) begin
         fp_in = sat_inc(fp_ff);
      end else if (true_label == LABEL_ONE && predicted_label == LABEL_ZERO) begin
         fn_in = sat_inc(fn_ff);
      end else begin
         tp_in = tp_ff;
      end
      if (true_label == predicted_label) begin
         match_in = sat_inc(match_ff);
      end
      cls_mid = note_label(true_label, cls_ff);
      cls_in  = note_label(predicted_label, cls_mid);
   end

   assign snap_push = accept && last_item;
   assign snap_data = {cls_in[CLS_BITS-1], items_in, match_in, fn_in, fp_in, tp_in};

   always_ff @(posedge clock) begin
      if (reset || snap_push) begin
         tp_ff    <= '0;
         fp_ff    <= '0;
         fn_ff    <= '0;
         match_ff <= '0;
         items_ff <= '0;
         cls_ff   <= '0;
      end else if (accept) begin
         tp_ff    <= tp_in;
         fp_ff    <= fp_in;
         fn_ff    <= fn_in;
         match_ff <= match_in;
         items_ff <= items_in;
         cls_ff   <= cls_in;
      end
   end

endmodule

### hdl/bcm_queue.sv
// ----------------------------------------------------------------------------
// bcm_queue
// Two-entry queue of finished-set snapshots between the front and back ends.
// ----------------------------------------------------------------------------
module bcm_queue #(
   parameter int SNAP_BITS = 101
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [SNAP_BITS-1:0]  push_data,
   input  logic                  pop,
   output logic [SNAP_BITS-1:0]  pop_data,
   output bcm_pkg::q_status_type status
);
   import bcm_pkg::*;

   localparam int DEPTH    = 2;
   localparam int PTR_BITS = $clog2(DEPTH);

   logic [SNAP_BITS-1:0] slot_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0]    fill_ff, fill_in;

   assign status.full  = (fill_ff == (PTR_BITS+1)'(DEPTH));
   assign status.empty = (fill_ff == '0);
   assign pop_data     = slot_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + (PTR_BITS+1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (PTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/bcm_back.sv
// ----------------------------------------------------------------------------
// bcm_back
// Pops set snapshots and works out accuracy, precision, recall and F1 with
// one shared restoring divider, one quotient bit per cycle, then presents
// the result in the output register.
// ----------------------------------------------------------------------------
module bcm_back #(
   parameter int COUNT_BITS    = 20,
   parameter int FRACTION_BITS = 16,
   parameter int SNAP_BITS     = 101,
   parameter int RSP_BITS      = 168
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bcm_pkg::q_status_type q_status,
   input  logic [SNAP_BITS-1:0]  snap_data,
   output logic                  snap_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [RSP_BITS-1:0]   rsp_data,
   output logic                  rsp_status
);
   import bcm_pkg::*;

   localparam int FRAC_W    = FRACTION_BITS + 1;
   localparam int DEN_BITS  = COUNT_BITS + 2;
   localparam int REM_BITS  = COUNT_BITS + 3;
   localparam int STEP_BITS = $clog2(FRAC_W);
   localparam int CB        = COUNT_BITS;

   back_state_type state_ff, state_in;
   metric_op_type  op_ff, op_in;
   logic [STEP_BITS-1:0] step_ff, step_in;

   logic [CB-1:0]       tp_ff, fp_ff, fn_ff, match_ff, items_ff;
   logic                ovf_ff;
   logic [DEN_BITS-1:0] den_prec_ff, den_rec_ff, den_f1_ff;
   logic [REM_BITS-1:0] rem_ff, rem_in;
   logic [FRAC_W-1:0]   quo_ff, quo_in;
   logic [FRAC_W-1:0]   acc_ff, prec_ff, rec_ff, f1_ff;
   logic                rsp_valid_ff;
   logic [RSP_BITS-1:0] rsp_data_ff;
   logic                rsp_status_ff;

   logic [REM_BITS-1:0] num_sel, rem_shift;
   logic [DEN_BITS-1:0] den_sel;
   logic [FRAC_W-1:0]   quo_final;
   logic                bit_set, last_step, load_job, store_quo, load_rsp;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // operand select for the metric in flight
   always_comb begin
      unique case (op_ff)
         OP_ACCURACY: begin
            num_sel = REM_BITS'(match_ff);
            den_sel = DEN_BITS'(items_ff);
         end
         OP_PRECISION: begin
            num_sel = REM_BITS'(tp_ff);
            den_sel = den_prec_ff;
         end
         OP_RECALL: begin
            num_sel = REM_BITS'(tp_ff);
            den_sel = den_rec_ff;
         end
         OP_F1: begin
            num_sel = REM_BITS'({tp_ff, 1'b0});
            den_sel = den_f1_ff;
         end
         default: begin
            num_sel = '0;
            den_sel = '0;
         end
      endcase
   end

   // first step compares the numerator itself, later steps shift the remainder
   assign rem_shift = (step_ff == '0) ? num_sel : {rem_ff[REM_BITS-2:0], 1'b0};
   assign bit_set   = (rem_shift >= REM_BITS'(den_sel));
   assign rem_in    = bit_set ? rem_shift - REM_BITS'(den_sel) : rem_shift;
   assign quo_in    = {quo_ff[FRAC_W-2:0], bit_set};
   assign last_step = (step_ff == STEP_BITS'(FRACTION_BITS));
   assign quo_final = (den_sel == '0) ? '0 : quo_in;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      step_in   = step_ff;
      snap_pop  = 1'b0;
      load_job  = 1'b0;
      store_quo = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               snap_pop = 1'b1;
               load_job = 1'b1;
               op_in    = OP_ACCURACY;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (last_step) begin
               store_quo = 1'b1;
               step_in   = '0;
               if (op_ff == OP_F1) begin
                  state_in = ST_HOLD;
               end else begin
                  op_in = metric_op_type'(op_ff + 2'd1);
               end
            end else begin
               step_in = step_ff + STEP_BITS'(1);
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_ACCURACY;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         step_ff  <= step_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_job) begin
         tp_ff       <= snap_data[0*CB +: CB];
         fp_ff       <= snap_data[1*CB +: CB];
         fn_ff       <= snap_data[2*CB +: CB];
         match_ff    <= snap_data[3*CB +: CB];
         items_ff    <= snap_data[4*CB +: CB];
         ovf_ff      <= snap_data[5*CB];
         den_prec_ff <= DEN_BITS'(snap_data[0*CB +: CB]) + DEN_BITS'(snap_data[1*CB +: CB]);
         den_rec_ff  <= DEN_BITS'(snap_data[0*CB +: CB]) + DEN_BITS'(snap_data[2*CB +: CB]);
         den_f1_ff   <= DEN_BITS'({snap_data[0*CB +: CB], 1'b0})
                        + DEN_BITS'(snap_data[1*CB +: CB]) + DEN_BITS'(snap_data[2*CB +: CB]);
      end
      if (state_ff == ST_DIV) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (store_quo) begin
         unique case (op_ff)
            OP_ACCURACY:  acc_ff  <= quo_final;
            OP_PRECISION: prec_ff <= quo_final;
            OP_RECALL:    rec_ff  <= quo_final;
            OP_F1:        f1_ff   <= quo_final;
            default:      acc_ff  <= quo_final;
         endcase
      end
      if (load_rsp) begin
         // a third distinct label zeroes the class-based ratios
         rsp_data_ff <= RSP_BITS'({
            ovf_ff ? FRAC_W'(0) : f1_ff,
            ovf_ff ? FRAC_W'(0) : rec_ff,
            ovf_ff ? FRAC_W'(0) : prec_ff,
            acc_ff, items_ff, match_ff, fn_ff, fp_ff, tp_ff});
         rsp_status_ff <= ovf_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;

endmodule

### tb/binary_classification_metrics_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_classification_metrics_test
// Streams label-pair sets into the metrics block and checks every result beat
// field by field against a scoreboard fed by a cycle-free predictor. Covers
// zero denominators, labels outside 0 and 1, the third-label error, and
// random sets under three sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module binary_classification_metrics_test;

   localparam int COUNT_BITS    = 20;
   localparam int FRACTION_BITS = 16;
   localparam int LABEL_BITS    = 8;
   localparam int RATIO_BITS    = FRACTION_BITS + 1;
   localparam int ITEM_TARGET   = 1850;
   localparam int SETTLE_CYCLES = 150;
   localparam longint CYCLE_LIMIT = 4_000_000;

   localparam bit [COUNT_BITS-1:0] COUNT_FULL = '1;

   typedef struct packed {
      bit [LABEL_BITS-1:0] true_label;
      bit [LABEL_BITS-1:0] predicted_label;
      bit                  last;
      bit                  drain_first;   // hold until every result is back
      bit [1:0]            phase;
   } pair_beat_type;

   typedef struct packed {
      bit [COUNT_BITS-1:0] tp;
      bit [COUNT_BITS-1:0] fp;
      bit [COUNT_BITS-1:0] fn;
      bit [COUNT_BITS-1:0] match_count;
      bit [COUNT_BITS-1:0] samples;
      bit [RATIO_BITS-1:0] accuracy;
      bit [RATIO_BITS-1:0] precision;
      bit [RATIO_BITS-1:0] recall;
      bit [RATIO_BITS-1:0] f1;
      bit                  status;
   } set_score_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [15:0]  req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [167:0] rsp_tdata;
   logic         rsp_tuser;

   binary_classification_metrics DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   pair_beat_type backlog[$];
   set_score_type pending_scores[$];

   int send_idle_pct[3] = '{37, 49, 0};
   int recv_idle_pct[3] = '{49, 37, 0};
   bit [1:0] cur_phase = 2'd0;
   bit       req_taken = 1'b0;
   int       queued = 0;
   int       beats_in = 0;
   int       results_seen = 0;
   int       mismatches = 0;
   longint   cycles = 0;

   // running tallies of the set in progress
   bit [COUNT_BITS-1:0] tally_tp, tally_fp, tally_fn, tally_eq, tally_n;
   bit [LABEL_BITS-1:0] class_a, class_b;
   bit [1:0]            class_cnt;
   bit                  too_many_classes;

   function automatic void clear_tallies();
      tally_tp = '0;
      tally_fp = '0;
      tally_fn = '0;
      tally_eq = '0;
      tally_n = '0;
      class_a = '0;
      class_b = '0;
      class_cnt = '0;
      too_many_classes = 1'b0;
   endfunction

   function automatic bit [COUNT_BITS-1:0] bump(input bit [COUNT_BITS-1:0] c);
      return (c == COUNT_FULL) ? c : c + COUNT_BITS'(1);
   endfunction

   // floor(num * 2^FRACTION_BITS / den), zero for an empty denominator
   function automatic bit [RATIO_BITS-1:0] q_ratio(input bit [63:0] num, input bit [63:0] den);
      if (den == 0)
         return '0;
      return RATIO_BITS'((num << FRACTION_BITS) / den);
   endfunction

   function automatic void note_class(input bit [LABEL_BITS-1:0] v);
      if (class_cnt >= 2'd1 && v == class_a)
         return;
      if (class_cnt >= 2'd2 && v == class_b)
         return;
      if (class_cnt == 2'd0) begin
         class_a = v;
         class_cnt = 2'd1;
      end else if (class_cnt == 2'd1) begin
         class_b = v;
         class_cnt = 2'd2;
      end else begin
         too_many_classes = 1'b1;
      end
   endfunction

   function automatic bit score_pair(input bit [LABEL_BITS-1:0] t, input bit [LABEL_BITS-1:0] p,
                                     input bit last, output set_score_type s);
      bit [63:0] tp, fp, fn;
      s = '0;
      note_class(t);
      note_class(p);
      if (t == LABEL_BITS'(1) && p == LABEL_BITS'(1))
         tally_tp = bump(tally_tp);
      else if (t == LABEL_BITS'(0) && p == LABEL_BITS'(1))
         tally_fp = bump(tally_fp);
      else if (t == LABEL_BITS'(1) && p == LABEL_BITS'(0))
         tally_fn = bump(tally_fn);
      if (t == p)
         tally_eq = bump(tally_eq);
      tally_n = bump(tally_n);
      if (!last)
         return 1'b0;
      tp = 64'(tally_tp);
      fp = 64'(tally_fp);
      fn = 64'(tally_fn);
      s.tp = tally_tp;
      s.fp = tally_fp;
      s.fn = tally_fn;
      s.match_count = tally_eq;
      s.samples = tally_n;
      s.accuracy = q_ratio(64'(tally_eq), 64'(tally_n));
      if (too_many_classes) begin
         s.status = 1'b1;
      end else begin
         s.precision = q_ratio(tp, tp + fp);
         s.recall = q_ratio(tp, tp + fn);
         s.f1 = q_ratio(tp << 1, (tp << 1) + fp + fn);
      end
      clear_tallies();
      return 1'b1;
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10)
         $display("MISMATCH at result %0d: %s", results_seen, what);
   endtask

   task automatic check_field(input string name, input bit [63:0] want, input bit [63:0] got);
      if (want != got)
         note_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
   endtask

   task automatic add_beat(input int t, input int p, input bit last, input bit [1:0] ph,
                           input bit drain = 1'b0);
      pair_beat_type b;
      b.true_label = LABEL_BITS'(t);
      b.predicted_label = LABEL_BITS'(p);
      b.last = last;
      b.drain_first = drain;
      b.phase = ph;
      backlog.push_back(b);
      queued++;
   endtask

   task automatic add_random_set(input bit [1:0] ph, input bit drain);
      int len, kind, bias, agree;
      bit [LABEL_BITS-1:0] la, lb, t, p;
      kind = int'($urandom_range(9));
      len = ($urandom_range(7) == 0) ? int'($urandom_range(150, 40))
                                     : int'($urandom_range(20, 1));
      bias = int'($urandom_range(100));
      agree = int'($urandom_range(100));
      la = LABEL_BITS'($urandom);
      lb = LABEL_BITS'($urandom);
      if (kind == 7)
         la = LABEL_BITS'(1);
      for (int i = 0; i < len; i++) begin
         if (kind <= 6) begin
            t = ($urandom_range(99) < bias) ? LABEL_BITS'(1) : LABEL_BITS'(0);
            p = ($urandom_range(99) < agree) ? t : (t ^ LABEL_BITS'(1));
         end else if (kind <= 8) begin
            t = ($urandom_range(1) != 0) ? la : lb;
            p = ($urandom_range(99) < agree) ? t : (($urandom_range(1) != 0) ? la : lb);
         end else begin
            // noise: arbitrary labels, mostly tripping the third-class error
            t = LABEL_BITS'($urandom);
            p = LABEL_BITS'($urandom);
         end
         add_beat(int'(t), int'(p), i == len - 1, ph, drain && i == 0);
      end
   endtask

   // sender and receiver, both moving on the falling edge
   always @(negedge clock) begin
      pair_beat_type b;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (backlog.size() != 0 && !(backlog[0].drain_first && pending_scores.size() != 0)
                && $urandom_range(99) >= send_idle_pct[backlog[0].phase]) begin
               b = backlog.pop_front();
               cur_phase = b.phase;
               req_tdata <= {b.predicted_label, b.true_label};
               req_tlast <= b.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct[cur_phase]);
      end
   end

   // monitor and scoreboard on the rising edge
   always @(posedge clock) begin
      set_score_type fresh, want, got;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            beats_in++;
            if (score_pair(req_tdata[7:0], req_tdata[15:8], req_tlast, fresh))
               pending_scores.push_back(fresh);
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got.tp = rsp_tdata[19:0];
            got.fp = rsp_tdata[39:20];
            got.fn = rsp_tdata[59:40];
            got.match_count = rsp_tdata[79:60];
            got.samples = rsp_tdata[99:80];
            got.accuracy = rsp_tdata[116:100];
            got.precision = rsp_tdata[133:117];
            got.recall = rsp_tdata[150:134];
            got.f1 = rsp_tdata[167:151];
            got.status = rsp_tuser;
            if (pending_scores.size() == 0) begin
               note_mismatch("result beat with no set pending");
            end else begin
               want = pending_scores.pop_front();
               check_field("true_positives", 64'(want.tp), 64'(got.tp));
               check_field("false_positives", 64'(want.fp), 64'(got.fp));
               check_field("false_negatives", 64'(want.fn), 64'(got.fn));
               check_field("matches_res", 64'(want.match_count), 64'(got.match_count));
               check_field("sample_count", 64'(want.samples), 64'(got.samples));
               check_field("accuracy", 64'(want.accuracy), 64'(got.accuracy));
               check_field("precision", 64'(want.precision), 64'(got.precision));
               check_field("recall", 64'(want.recall), 64'(got.recall));
               check_field("f1_score", 64'(want.f1), 64'(got.f1));
               check_field("status", 64'(want.status), 64'(got.status));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                  pending_scores.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      clear_tallies();

      // directed sets
      add_beat(1, 1, 0, 0);            // one of each outcome
      add_beat(0, 1, 0, 0);
      add_beat(1, 0, 0, 0);
      add_beat(0, 0, 1, 0);
      add_beat(0, 0, 1, 0);            // no positives at all: empty denominators
      add_beat(1, 1, 1, 0);            // perfect score
      add_beat(255, 0, 0, 0);          // third label trips the error
      add_beat(1, 1, 1, 0);
      add_beat(0, 255, 1, 0);          // two classes, no hits, accuracy zero
      add_beat(2, 2, 0, 0);            // foreign label counts only as a match
      add_beat(1, 1, 1, 0);
      add_beat(1, 0, 0, 0);            // nonzero denominators, zero hits
      add_beat(0, 1, 0, 0);
      add_beat(0, 1, 1, 0);
      add_beat(0, 1, 0, 0);            // error sticks for the rest of the set
      add_beat(5, 5, 0, 0);
      add_beat(0, 1, 0, 0);
      add_beat(1, 1, 1, 0);
      add_beat(128, 127, 1, 0);
      add_beat(170, 85, 0, 0);
      add_beat(85, 170, 1, 0);

      // random sets, one block per idling mix
      for (int ph = 0; ph < 3; ph++) begin
         add_random_set(2'(ph), ph != 0);
         while (queued < ITEM_TARGET * (ph + 1) / 3)
            add_random_set(2'(ph), 1'b0);
      end

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      while (backlog.size() != 0 || req_tvalid)
         @(posedge clock);
      while (pending_scores.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Scored %0d sets from %0d label-pair beats under three idling mixes.",
               results_seen, beats_in);
      $display("Sets mixed clean binary labels, foreign labels and third-label errors.");
      if (mismatches == 0 && pending_scores.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
